// File: hdl/esest_pkg.sv
// Shared types and constants of the encoder speed estimator.
`timescale 1ns / 1ps
`default_nettype none

package esest_pkg;

	localparam int TIME_W  = 32;
	localparam int CNT_W   = 16;
	localparam int CPR_W   = 16;
	localparam int TRV_W   = 32;
	localparam int SPD_W   = 48;
	localparam int ROUTE_W = 64;
	localparam int DIST_W  = 64;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	// shared divider: dividend is left-aligned, quotient comes out right-aligned
	localparam int DIV_W  = 74;
	localparam int DVS_W  = 32;
	localparam int STEP_W = 7;

	localparam logic [STEP_W-1:0] STEPS_DIST  = STEP_W'(64);
	localparam logic [STEP_W-1:0] STEPS_SPEED = STEP_W'(74);
	localparam logic [STEP_W-1:0] STEPS_ACCEL = STEP_W'(59);
	localparam int ACCEL_ALIGN = DIV_W - 59;

	localparam logic [SPD_W-1:0] POS_LIM = 48'h7FFF_FFFF_FFFF;
	localparam logic [SPD_W-1:0] NEG_LIM = 48'h8000_0000_0000;

	localparam logic [CFG_IDX_W-1:0] REG_COUNTS_PER_REV = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TRAVEL_PER_REV = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_REVERSE_DIR    = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PREP,
		ST_MUL,
		ST_DIV_DIST,
		ST_LOAD_SPEED,
		ST_DIV_SPEED,
		ST_DIFF,
		ST_LOAD_ACCEL,
		ST_DIV_ACCEL,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic              start;
		logic [STEP_W-1:0] steps;
	} div_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	// x * 1000 as shifts and subtracts (1024 - 16 - 8)
	function automatic logic [DIV_W-1:0] times_k(input logic [DIV_W-1:0] x);
		return (x << 10) - (x << 4) - (x << 3);
	endfunction

endpackage

`default_nettype wire

// File: hdl/esest_if.sv
// Item channels of the encoder speed estimator: sample input and result output.
`timescale 1ns / 1ps
`default_nettype none

interface esest_in_if;
	import esest_pkg::*;
	logic                     valid;
	logic                     ready;
	logic        [TIME_W-1:0] now_time;
	logic signed [CNT_W-1:0]  count_change;

	modport source (output valid, now_time, count_change, input ready);
	modport sink (input valid, now_time, count_change, output ready);
endinterface

interface esest_out_if;
	import esest_pkg::*;
	logic                      valid;
	logic                      ready;
	logic signed [SPD_W-1:0]   speed_raw;
	logic signed [SPD_W-1:0]   speed_median;
	logic signed [SPD_W-1:0]   accel;
	logic signed [ROUTE_W-1:0] route_total;
	logic                      sample_taken;

	modport source (output valid, speed_raw, speed_median, accel, route_total, sample_taken,
		input ready);
	modport sink (input valid, speed_raw, speed_median, accel, route_total, sample_taken,
		output ready);
endinterface

`default_nettype wire

// File: hdl/encoder_speed_estimator.sv
// Top level of the encoder speed estimator: sequencer, datapath and state.
//
// Usage: each item on the sample channel carries a wrapping millisecond
// timestamp (now_time) and the signed encoder count change since the last
// item. Each accepted item yields exactly one item on the result channel:
// instant speed, median of the last three speeds, acceleration, route total
// (all signed fixed point with FRAC_BITS fraction bits) and sample_taken.
// A taken sample runs three divisions on one shared one-bit-per-cycle
// divider (64 steps for distance, 74 for speed, 59 for acceleration) and
// then loads its result into the result register once that register is free.
// A skipped sample (zero elapsed time or counts_per_rev of zero) only folds its
// counts into the pending sum and goes from ST_PREP straight to ST_EMIT.
// One item is in work at a time; sample.ready is high only while idle, so the
// next item is taken only once the sequencer is back in ST_IDLE. The
// result register is separate, so a new item is taken while the previous result
// still waits. When the receiver stalls, the result is held; a finished item then
// waits in the sequencer until the result register frees up.
// Reset clears the timestamp, pending counts, speed history and route total and
// loads counts_per_rev = 1, travel_per_rev = 1.0, reverse_dir = 0.
// Configuration: write cfg_data to register cfg_index while cfg_we is high;
// write only while no item is in work. Unknown indexes are ignored.
`timescale 1ns / 1ps
`default_nettype none

module encoder_speed_estimator #(
	parameter int FRAC_BITS = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	esest_in_if.sink                             sample,
	esest_out_if.source                          result,
	input  logic                                 cfg_we,
	input  logic [esest_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [esest_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import esest_pkg::*;

	// configuration
	logic [CPR_W-1:0] counts_per_rev_q;
	logic [TRV_W-1:0] travel_per_rev_q;
	logic             reverse_dir_q;

	// block state
	logic        [TIME_W-1:0]  last_time_q;
	logic signed [31:0]        pending_q;
	logic signed [SPD_W-1:0]   hist_q [3];
	logic        [ROUTE_W-1:0] route_q;

	// item in work
	state_t                    state_q, state_nxt;
	logic        [TIME_W-1:0]  time_q;
	logic signed [CNT_W-1:0]   cnt_q;
	logic        [TIME_W-1:0]  dt_q;
	logic        [31:0]        mag_q;
	logic                      neg_q;
	logic                      taken_q;
	logic        [DIST_W-1:0]  dmag_q;
	logic signed [SPD_W-1:0]   speed_q;
	logic        [SPD_W:0]     diff_mag_q;
	logic                      dneg_q;
	logic signed [SPD_W-1:0]   accel_q;

	// result register
	logic                      out_valid_q;
	logic signed [SPD_W-1:0]   out_speed_q;
	logic signed [SPD_W-1:0]   out_median_q;
	logic signed [SPD_W-1:0]   out_accel_q;
	logic signed [ROUTE_W-1:0] out_route_q;
	logic                      out_taken_q;

	// shared divider
	div_req_t              div_req;
	div_stat_t             div_stat;
	logic [DIV_W-1:0]      div_dividend;
	logic [DVS_W-1:0]      div_divisor;
	logic [DIV_W-1:0]      div_quotient;

	// control
	logic accept;
	logic out_load;

	// combinational datapath terms
	logic        [TIME_W-1:0] dt;
	logic signed [32:0]       sum33;
	logic        [31:0]       total;
	logic                     skip;
	logic signed [SPD_W:0]    diff;
	logic signed [SPD_W-1:0]  sat_q_val;
	logic        [DIST_W-1:0] dist_signed;

	function automatic logic signed [SPD_W-1:0] sat_signed(input logic neg,
		input logic [DIV_W-1:0] q);
		logic [SPD_W-1:0] lim;
		logic [SPD_W-1:0] mag;
		begin
			lim = neg ? NEG_LIM : POS_LIM;
			mag = (q > DIV_W'(lim)) ? lim : q[SPD_W-1:0];
			return neg ? $signed(-mag) : $signed(mag);
		end
	endfunction

	function automatic logic signed [SPD_W-1:0] med3(input logic signed [SPD_W-1:0] a,
		input logic signed [SPD_W-1:0] b, input logic signed [SPD_W-1:0] c);
		logic signed [SPD_W-1:0] lo;
		logic signed [SPD_W-1:0] hi;
		logic signed [SPD_W-1:0] m;
		begin
			lo = (a < b) ? a : b;
			hi = (a < b) ? b : a;
			m  = (hi < c) ? hi : c;
			return (lo > m) ? lo : m;
		end
	endfunction

	esest_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.stat     (div_stat),
		.quotient (div_quotient)
	);

	// elapsed time and the saturated pending total
	always_comb begin
		dt    = time_q - last_time_q;
		sum33 = {pending_q[31], pending_q} + {{(33 - CNT_W){cnt_q[CNT_W-1]}}, cnt_q};
		if (sum33[32] != sum33[31]) begin
			total = sum33[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
		end else begin
			total = sum33[31:0];
		end
		skip        = (dt == '0) || (counts_per_rev_q == '0);
		diff        = {speed_q[SPD_W-1], speed_q} - {hist_q[0][SPD_W-1], hist_q[0]};
		sat_q_val   = sat_signed(state_q == ST_DIV_ACCEL ? dneg_q : neg_q, div_quotient);
		dist_signed = neg_q ? -dmag_q : dmag_q;
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE:       if (accept) state_nxt = ST_PREP;
			ST_PREP:       state_nxt = skip ? ST_EMIT : ST_MUL;
			ST_MUL:        state_nxt = ST_DIV_DIST;
			ST_DIV_DIST:   if (div_stat.done) state_nxt = ST_LOAD_SPEED;
			ST_LOAD_SPEED: state_nxt = ST_DIV_SPEED;
			ST_DIV_SPEED:  if (div_stat.done) state_nxt = ST_DIFF;
			ST_DIFF:       state_nxt = ST_LOAD_ACCEL;
			ST_LOAD_ACCEL: state_nxt = ST_DIV_ACCEL;
			ST_DIV_ACCEL:  if (div_stat.done) state_nxt = ST_EMIT;
			ST_EMIT:       if (out_load) state_nxt = ST_IDLE;
			default:       state_nxt = ST_IDLE;
		endcase
	end

	// sequencer outputs: handshake, divider commands and operands
	always_comb begin
		sample.ready  = 1'b0;
		out_load      = 1'b0;
		div_req.start = 1'b0;
		div_req.steps = STEPS_DIST;
		div_dividend  = '0;
		div_divisor   = dt_q;
		case (state_q)
			ST_IDLE: begin
				sample.ready = 1'b1;
			end
			ST_MUL: begin
				// product of |total| and travel, left-aligned over 64 steps
				div_req.start = 1'b1;
				div_req.steps = STEPS_DIST;
				div_dividend  = {64'(mag_q) * 64'(travel_per_rev_q), 10'b0};
				div_divisor   = DVS_W'(counts_per_rev_q);
			end
			ST_LOAD_SPEED: begin
				div_req.start = 1'b1;
				div_req.steps = STEPS_SPEED;
				div_dividend  = times_k(DIV_W'(dmag_q));
			end
			ST_LOAD_ACCEL: begin
				div_req.start = 1'b1;
				div_req.steps = STEPS_ACCEL;
				div_dividend  = times_k(DIV_W'(diff_mag_q)) << ACCEL_ALIGN;
			end
			ST_EMIT: begin
				out_load = !out_valid_q || result.ready;
			end
			default: begin
				div_req.start = 1'b0;
			end
		endcase
	end

	assign accept = sample.valid && sample.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= ST_IDLE;
			out_valid_q      <= 1'b0;
			counts_per_rev_q <= CPR_W'(1);
			travel_per_rev_q <= TRV_W'(1) << FRAC_BITS;
			reverse_dir_q    <= 1'b0;
			last_time_q      <= '0;
			pending_q        <= '0;
			hist_q[0]        <= '0;
			hist_q[1]        <= '0;
			hist_q[2]        <= '0;
			route_q          <= '0;
		end else begin
			state_q <= state_nxt;

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end

			if (cfg_we) begin
				case (cfg_index)
					REG_COUNTS_PER_REV: counts_per_rev_q <= cfg_data[CPR_W-1:0];
					REG_TRAVEL_PER_REV: travel_per_rev_q <= cfg_data[TRV_W-1:0];
					REG_REVERSE_DIR:    reverse_dir_q    <= cfg_data[0];
					default:            ;
				endcase
			end

			// skipped sample: keep the counts for the next taken one
			if (state_q == ST_PREP && skip) begin
				pending_q <= $signed(total);
			end

			// distance is known: commit route, timestamp, clear pending
			if (state_q == ST_LOAD_SPEED) begin
				route_q     <= route_q + dist_signed;
				last_time_q <= time_q;
				pending_q   <= '0;
			end

			// accel done: shift the new speed into the history
			if (state_q == ST_DIV_ACCEL && div_stat.done) begin
				hist_q[2] <= hist_q[1];
				hist_q[1] <= hist_q[0];
				hist_q[0] <= speed_q;
			end
		end
	end

	// item payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			time_q <= sample.now_time;
			cnt_q  <= sample.count_change;
		end
		if (state_q == ST_PREP) begin
			dt_q    <= dt;
			mag_q   <= total[31] ? -total : total;
			neg_q   <= total[31] ^ reverse_dir_q;
			taken_q <= !skip;
		end
		if (state_q == ST_DIV_DIST && div_stat.done) begin
			dmag_q <= div_quotient[DIST_W-1:0];
		end
		if (state_q == ST_DIV_SPEED && div_stat.done) begin
			speed_q <= sat_q_val;
		end
		if (state_q == ST_DIFF) begin
			dneg_q     <= diff[SPD_W];
			diff_mag_q <= diff[SPD_W] ? $unsigned(-diff) : $unsigned(diff);
		end
		if (state_q == ST_DIV_ACCEL && div_stat.done) begin
			accel_q <= sat_q_val;
		end
		if (out_load) begin
			out_speed_q  <= taken_q ? speed_q : '0;
			out_accel_q  <= taken_q ? accel_q : '0;
			out_median_q <= med3(hist_q[0], hist_q[1], hist_q[2]);
			out_route_q  <= $signed(route_q);
			out_taken_q  <= taken_q;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.speed_raw    = out_speed_q;
	assign result.speed_median = out_median_q;
	assign result.accel        = out_accel_q;
	assign result.route_total  = out_route_q;
	assign result.sample_taken = out_taken_q;

	// the divider only runs while the sequencer is inside a computation
	a_ready_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		sample.ready |-> !div_stat.busy)
		else $error("sample accepted while divider busy");

	a_done_in_div_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done |-> (state_q == ST_DIV_DIST || state_q == ST_DIV_SPEED ||
			state_q == ST_DIV_ACCEL))
		else $error("divider finished outside a divide state");

	a_skip_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && !result.sample_taken) |-> (result.speed_raw == '0 &&
			result.accel == '0))
		else $error("skipped sample with nonzero speed or accel");

	a_emit_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT && result.valid && !result.ready) |=> state_q == ST_EMIT)
		else $error("result overwritten while stalled");

endmodule

`default_nettype wire

// File: hdl/esest_div.sv
// Shared restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module esest_div (
	input  logic                             clk,
	input  logic                             arst_n,
	input  esest_pkg::div_req_t              req,
	input  logic [esest_pkg::DIV_W-1:0]      dividend,
	input  logic [esest_pkg::DVS_W-1:0]      divisor,
	output esest_pkg::div_stat_t             stat,
	output logic [esest_pkg::DIV_W-1:0]      quotient
);
	import esest_pkg::*;

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] cnt_q;
	logic [DVS_W-1:0]  rem_q;
	logic [DVS_W-1:0]  dvs_q;
	logic [DIV_W-1:0]  quo_q;

	logic [DVS_W:0]    shifted;
	logic [DVS_W+1:0]  trial;
	logic              q_bit;
	logic [DVS_W-1:0]  rem_nxt;

	always_comb begin
		shifted = {rem_q, quo_q[DIV_W-1]};
		trial   = {1'b0, shifted} - {2'b00, dvs_q};
		q_bit   = ~trial[DVS_W+1];
		rem_nxt = q_bit ? trial[DVS_W-1:0] : shifted[DVS_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - STEP_W'(1);
				if (cnt_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			dvs_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= rem_nxt;
			quo_q <= {quo_q[DIV_W-2:0], q_bit};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = quo_q;

endmodule

`default_nettype wire

// File: verif/tb_top.sv
// Self-checking bench of the encoder speed estimator: directed table, pile-up runs, random phases.
`timescale 1ns / 1ps

module tb_top;
	import esest_pkg::*;

	localparam int FRAC          = 16;
	localparam int IDLE_LIMIT    = 3000;
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_ITEMS   = 85;
	localparam int PILE_ITEMS    = 20;
	localparam int PLAN_ROWS     = 29;
	localparam int MAX_PRINTS    = 50;

	// index with no register behind it; writes to it must leave the settings alone
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	localparam longint PEND_HI = 64'sd2147483647;
	localparam longint PEND_LO = -64'sd2147483648;

	typedef struct packed {
		logic [SPD_W-1:0]   speed_raw;
		logic [SPD_W-1:0]   speed_median;
		logic [SPD_W-1:0]   accel;
		logic [ROUTE_W-1:0] route_total;
		logic               sample_taken;
	} motion_t;

	typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_t;

	typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_PERIODIC} rx_mode_t;

	typedef struct {
		row_kind_t                    kind;
		logic        [CFG_IDX_W-1:0]  index;
		logic        [CFG_DATA_W-1:0] data;
		logic        [TIME_W-1:0]     now_time;
		logic signed [CNT_W-1:0]      count_change;
		logic                         typed_in;
		motion_t                      want;
	} plan_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	esest_in_if  smp();
	esest_out_if res();

	encoder_speed_estimator #(.FRAC_BITS(FRAC)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.sample(smp),
		.result(res),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Directed table. Rows with typed_in set carry a result that is plain from the
	// arithmetic: the skip right after reset, the first real speed at the reset
	// settings, and a skip that must leave the route alone. All other rows are
	// checked against the predictor.
	plan_row_t plan [PLAN_ROWS] = '{
		// zero elapsed time right after reset: skipped, everything zero
		'{ROW_SAMPLE, '0, '0, 32'd0, 16'sd5, 1'b1, '0},
		// 5 pending counts over 1 ms at one count per unit of travel
		'{ROW_SAMPLE, '0, '0, 32'd1, 16'sd0, 1'b1,
			'{48'd327680000, 48'd0, 48'd327680000000, 64'd327680, 1'b0 + 1'b1}},
		// most negative count at a repeated timestamp: skipped, route kept
		'{ROW_SAMPLE, '0, '0, 32'd1, 16'sh8000, 1'b1,
			'{48'd0, 48'd0, 48'd0, 64'd327680, 1'b0}},
		'{ROW_SAMPLE, '0, '0, 32'd2, 16'sh7FFF, 1'b0, '0},
		'{ROW_WRITE, REG_UNUSED, 32'hFFFF_FFFF, '0, '0, 1'b0, '0},
		// huge elapsed time, then a timestamp that wraps back to zero
		'{ROW_SAMPLE, '0, '0, 32'hFFFF_FFFF, 16'sh7FFF, 1'b0, '0},
		'{ROW_SAMPLE, '0, '0, 32'd0, 16'sh8000, 1'b0, '0},
		// zero counts per revolution: every item is skipped
		'{ROW_WRITE, REG_COUNTS_PER_REV, 32'd0, '0, '0, 1'b0, '0},
		'{ROW_SAMPLE, '0, '0, 32'd5, 16'sd100, 1'b0, '0},
		'{ROW_SAMPLE, '0, '0, 32'd9, -16'sd1, 1'b0, '0},
		// upper data bits must not reach the 16-bit register
		'{ROW_WRITE, REG_COUNTS_PER_REV, 32'h1234_FFFF, '0, '0, 1'b0, '0},
		'{ROW_SAMPLE, '0, '0, 32'd10, 16'sd1, 1'b0, '0},
		'{ROW_SAMPLE, '0, '0, 32'd11, 16'sh7FFF, 1'b0, '0},
		// longest travel, one count per revolution: speed and accel clip high
		'{ROW_WRITE, REG_COUNTS_PER_REV, 32'd1, '0, '0, 1'b0, '0},
		'{ROW_WRITE, REG_TRAVEL_PER_REV, 32'hFFFF_FFFF, '0, '0, 1'b0, '0},
		'{ROW_SAMPLE, '0, '0, 32'd12, 16'sh7FFF, 1'b0, '0},
		// reverse: the same motion now clips low
		'{ROW_WRITE, REG_REVERSE_DIR, 32'hFFFF_FFFF, '0, '0, 1'b0, '0},
		'{ROW_SAMPLE, '0, '0, 32'd13, 16'sh7FFF, 1'b0, '0},
		'{ROW_SAMPLE, '0, '0, 32'd14, 16'sd0, 1'b0, '0},
		// no travel per revolution: distance is zero whatever the counts
		'{ROW_WRITE, REG_TRAVEL_PER_REV, 32'd0, '0, '0, 1'b0, '0},
		'{ROW_SAMPLE, '0, '0, 32'd15, 16'sh8000, 1'b0, '0},
		'{ROW_WRITE, REG_TRAVEL_PER_REV, 32'h0001_0000, '0, '0, 1'b0, '0},
		'{ROW_WRITE, REG_REVERSE_DIR, 32'hFFFF_FFFE, '0, '0, 1'b0, '0},
		'{ROW_SAMPLE, '0, '0, 32'h8000_000F, 16'sh8000, 1'b0, '0},
		'{ROW_SAMPLE, '0, '0, 32'h8000_000F, 16'sd1, 1'b0, '0},
		'{ROW_SAMPLE, '0, '0, 32'h8000_0010, 16'sh7FFF, 1'b0, '0},
		'{ROW_SAMPLE, '0, '0, 32'h8000_0013, -16'sd7, 1'b0, '0},
		'{ROW_SAMPLE, '0, '0, 32'h8000_0013, 16'sd0, 1'b0, '0},
		'{ROW_SAMPLE, '0, '0, 32'h8000_0014, 16'sd0, 1'b0, '0}
	};

	// Predictor copy of the settings and the estimator state
	logic [CPR_W-1:0]   cpr_q;
	logic [TRV_W-1:0]   travel_q;
	logic               reverse_q;
	logic [TIME_W-1:0]  last_stamp;
	int                 pending_sum;
	longint             speed_hist [3];
	logic [ROUTE_W-1:0] route_sum;

	motion_t expected_motion [$];
	int      mismatches = 0;
	int      burst_left = 0;
	bit      quiet = 1'b0;

	// min(mag * 1000 / div, lim), kept inside 64 bits by splitting off the remainder
	function automatic logic [63:0] per_second(input logic [63:0] mag, input logic [31:0] div,
		input logic [63:0] lim);
		logic [63:0] quo;
		logic [63:0] rem;
		logic [63:0] val;
		quo = mag / div;
		rem = mag % div;
		if (quo > lim / 1000)
			return lim;
		val = quo * 1000 + rem * 1000 / div;
		return (val > lim) ? lim : val;
	endfunction

	// divide the magnitude, then apply the sign; clip asymmetric at 48 bits
	function automatic longint signed_rate(input logic neg, input logic [63:0] mag,
		input logic [31:0] div);
		if (neg)
			return -$signed(per_second(mag, div, {16'd0, NEG_LIM}));
		return $signed(per_second(mag, div, {16'd0, POS_LIM}));
	endfunction

	function automatic longint middle_of(input longint a, input longint b, input longint c);
		longint t;
		if (a > b) begin
			t = a; a = b; b = t;
		end
		if (b > c) begin
			t = b; b = c; c = t;
		end
		if (a > b) begin
			t = a; a = b; b = t;
		end
		return b;
	endfunction

	// Advance the predictor by one sample and return the result it must cause
	function automatic motion_t estimate_motion(input logic [TIME_W-1:0] now,
		input logic signed [CNT_W-1:0] cnt);
		logic [TIME_W-1:0] dt;
		longint            sum;
		int                total;
		logic              neg;
		logic              dneg;
		logic              taken;
		logic [63:0]       mag;
		logic [63:0]       dist_mag;
		longint            spd;
		longint            acc;
		longint            diff;
		motion_t           m;
		dt = now - last_stamp;
		sum = longint'(pending_sum) + longint'(cnt);
		if (sum > PEND_HI)
			total = int'(PEND_HI);
		else if (sum < PEND_LO)
			total = int'(PEND_LO);
		else
			total = int'(sum);
		spd = 0;
		acc = 0;
		taken = (dt != 0) && (cpr_q != 0);
		if (!taken) begin
			pending_sum = total;
		end else begin
			neg = total < 0;
			mag = neg ? -longint'(total) : longint'(total);
			dist_mag = mag * travel_q / cpr_q;
			if (reverse_q)
				neg = !neg;
			spd = signed_rate(neg, dist_mag, dt);
			diff = spd - speed_hist[0];
			dneg = diff < 0;
			acc = signed_rate(dneg, dneg ? -diff : diff, dt);
			speed_hist[2] = speed_hist[1];
			speed_hist[1] = speed_hist[0];
			speed_hist[0] = spd;
			route_sum = neg ? route_sum - dist_mag : route_sum + dist_mag;
			last_stamp = now;
			pending_sum = 0;
		end
		m.speed_raw = SPD_W'(spd);
		m.speed_median = SPD_W'(middle_of(speed_hist[0], speed_hist[1], speed_hist[2]));
		m.accel = SPD_W'(acc);
		m.route_total = route_sum;
		m.sample_taken = taken;
		return m;
	endfunction

	task report_mismatch(input string field, input logic [63:0] got, input logic [63:0] want);
		if (mismatches < MAX_PRINTS)
			$display("%0t ns: %s got %h want %h", $time, field, got, want);
		mismatches++;
	endtask

	// Offer one item; the sender works in bursts with random gaps between them.
	// Valid stays high from one item to the next inside a burst.
	task automatic push_sample(input logic [TIME_W-1:0] now, input logic signed [CNT_W-1:0] cnt,
		input logic typed_in, input motion_t want);
		motion_t predicted;
		if (!quiet && burst_left == 0) begin
			smp.valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = $urandom_range(1, 24);
		end
		if (burst_left > 0)
			burst_left--;
		smp.valid <= 1'b1;
		smp.now_time <= now;
		smp.count_change <= cnt;
		do @(posedge clk); while (!smp.ready);
		// item taken at this edge: advance the predictor in acceptance order
		predicted = estimate_motion(now, cnt);
		expected_motion.push_back(typed_in ? want : predicted);
	endtask

	// Drop valid and hold until every result is back and the block has settled
	task automatic drain_results();
		smp.valid <= 1'b0;
		burst_left = 0;
		while (expected_motion.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Registers change only while the block is idle; mirror each write in the predictor
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		drain_results();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_COUNTS_PER_REV: cpr_q = val[CPR_W-1:0];
			REG_TRAVEL_PER_REV: travel_q = val;
			REG_REVERSE_DIR:    reverse_q = val[0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	// Receiver: switch between open, coin-flip and periodic stalling every so often
	rx_mode_t rx_mode = RX_OPEN;
	int       rx_left = 0;
	int       rx_tick = 0;

	always @(posedge clk) begin
		rx_tick <= rx_tick + 1;
		if (rx_left == 0) begin
			rx_mode <= rx_mode_t'($urandom_range(0, 2));
			rx_left <= $urandom_range(40, 400);
		end else begin
			rx_left <= rx_left - 1;
		end
		case (rx_mode)
			RX_OPEN:   res.ready <= 1'b1;
			RX_RANDOM: res.ready <= quiet || ($urandom_range(0, 1) != 0);
			default:   res.ready <= quiet || (rx_tick % 29 < 9);
		endcase
	end

	// Compare each accepted result with the oldest expectation, field by field
	always @(posedge clk) begin
		motion_t head;
		if (arst_n && res.valid && res.ready) begin
			if (expected_motion.size() == 0) begin
				report_mismatch("result with nothing expected", res.route_total, '0);
			end else begin
				head = expected_motion.pop_front();
				if (res.speed_raw !== head.speed_raw)
					report_mismatch("speed_raw", 64'(res.speed_raw), 64'(head.speed_raw));
				if (res.speed_median !== head.speed_median)
					report_mismatch("speed_median", 64'(res.speed_median),
						64'(head.speed_median));
				if (res.accel !== head.accel)
					report_mismatch("accel", 64'(res.accel), 64'(head.accel));
				if (res.route_total !== head.route_total)
					report_mismatch("route_total", res.route_total, head.route_total);
				if (res.sample_taken !== head.sample_taken)
					report_mismatch("sample_taken", 64'(res.sample_taken),
						64'(head.sample_taken));
			end
		end
	end

	// Watchdog: end the run when nothing moves on any port for too long
	int idle_cycles = 0;

	always @(posedge clk) begin
		if ((smp.valid && smp.ready) || (res.valid && res.ready) || cfg_we) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		logic        [TIME_W-1:0] stamp;
		logic signed [CNT_W-1:0]  cnt;
		int                       pick;
		smp.valid <= 1'b0;
		smp.now_time <= '0;
		smp.count_change <= '0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		arst_n <= 1'b0;
		cpr_q = 16'd1;
		travel_q = 32'd1 << FRAC;
		reverse_q = 1'b0;
		last_stamp = '0;
		pending_sum = 0;
		speed_hist = '{0, 0, 0};
		route_sum = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// walk the directed table
		foreach (plan[i]) begin
			if (plan[i].kind == ROW_WRITE) begin
				write_reg(plan[i].index, plan[i].data);
			end else begin
				push_sample(plan[i].now_time, plan[i].count_change, plan[i].typed_in,
					plan[i].want);
			end
		end

		// Pile counts up at a frozen timestamp into a large pending sum,
		// then let one sample with elapsed time turn the sum into motion.
		// Run these stretches without idling on either side.
		quiet = 1'b1;
		stamp = last_stamp + 32'd1000;
		push_sample(stamp, 16'sd3, 1'b0, '0);
		for (int n = 0; n < PILE_ITEMS; n++)
			push_sample(stamp, 16'sh7FFF, 1'b0, '0);
		push_sample(stamp + 32'd1, 16'sh7FFF, 1'b0, '0);

		// with counts_per_rev at zero every item is skipped though time moves on;
		// drive the sum far negative and release it at the longest travel
		write_reg(REG_COUNTS_PER_REV, 32'd0);
		for (int n = 0; n < PILE_ITEMS; n++) begin
			stamp = stamp + 32'd1;
			push_sample(stamp, 16'sh8000, 1'b0, '0);
		end
		write_reg(REG_COUNTS_PER_REV, 32'd1);
		write_reg(REG_TRAVEL_PER_REV, 32'hFFFF_FFFF);
		stamp = stamp + 32'd3;
		push_sample(stamp, -16'sd5, 1'b0, '0);

		// Random phases, each under its own settings
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			quiet = (ph == 4);
			case (ph)
				0: begin
					write_reg(REG_COUNTS_PER_REV, 32'd1);
					write_reg(REG_TRAVEL_PER_REV, 32'h0001_0000);
					write_reg(REG_REVERSE_DIR, 32'd0);
				end
				1: begin
					write_reg(REG_COUNTS_PER_REV, 32'h0000_FFFF);
					write_reg(REG_TRAVEL_PER_REV, 32'hFFFF_FFFF);
					write_reg(REG_REVERSE_DIR, 32'd1);
				end
				2: begin
					// all skips: the pending sum wanders, the next phase releases it
					write_reg(REG_COUNTS_PER_REV, 32'd0);
				end
				3: begin
					write_reg(REG_COUNTS_PER_REV, 32'd1);
					write_reg(REG_TRAVEL_PER_REV, 32'hFFFF_FFFF);
					write_reg(REG_REVERSE_DIR, 32'd0);
				end
				default: begin
					if ($urandom_range(0, 3) == 0)
						write_reg(REG_COUNTS_PER_REV, $urandom_range(1, 8));
					else
						write_reg(REG_COUNTS_PER_REV, $urandom_range(1, 65535));
					write_reg(REG_TRAVEL_PER_REV, $urandom);
					write_reg(REG_REVERSE_DIR, $urandom_range(0, 1));
				end
			endcase
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				// timestamp: repeat, short step, long step or a jump anywhere
				pick = $urandom_range(0, 99);
				if (pick >= 90)
					stamp = $urandom;
				else if (pick >= 60)
					stamp = stamp + $urandom_range(21, 5000);
				else if (pick >= 12)
					stamp = stamp + $urandom_range(1, 20);
				// count: an extreme, a small move either way, or any 16-bit value
				pick = $urandom_range(0, 99);
				if (pick < 10)
					cnt = pick[0] ? 16'sh7FFF : 16'sh8000;
				else if (pick < 50)
					cnt = CNT_W'(int'($urandom_range(0, 400)) - 200);
				else
					cnt = CNT_W'($urandom);
				push_sample(stamp, cnt, 1'b0, '0);
			end
		end

		// wait out every expected result, then let the block settle
		drain_results();
		repeat (16) @(posedge clk);
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
